// File: src/xsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsr_pkg
// Shared constants, control word layout and microcode ROM of the xorshift64*
// generator.
// ----------------------------------------------------------------------------
package xsr_pkg;

    localparam int WORD_W  = 64;
    localparam int HALF_W  = 32;
    localparam int KIND_W  = 2;
    localparam int COUNT_W = 7;
    localparam int PC_W    = 5;

    // request kinds; the fourth code is ignored
    localparam logic [KIND_W-1:0] KIND_SEED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DRAW = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FILL = 2'd2;

    localparam logic [COUNT_W-1:0] MAX_FILL_BYTES = 7'd64;

    localparam logic [WORD_W-1:0] GOLDEN     = 64'h9e3779b97f4a7c15;
    localparam logic [WORD_W-1:0] MIX_MUL_A  = 64'hff51afd7ed558ccd;
    localparam logic [WORD_W-1:0] MIX_MUL_B  = 64'hc4ceb9fe1a85ec53;
    localparam logic [WORD_W-1:0] ZERO_SUBST = 64'h1d0f5c8c2e1b9a43;
    localparam logic [WORD_W-1:0] OUT_MUL    = 64'h2545f4914f6cdd1d;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,     // acc = value + golden
        OP_MIX,      // acc ^= acc >> 33
        OP_MUL0,     // prod = acc.lo * k.lo
        OP_MUL1,     // prod += (acc.hi * k.lo) << 32
        OP_MUL2,     // acc = prod + (acc.lo * k.hi) << 32
        OP_ABSORB,   // state ^= acc, zero substitute, mark seeded
        OP_STEP,     // xorshift 12/25/27, acc = new state
        OP_EMIT,     // hand out one result, ends item on the last one
        OP_FINISH
    } op_t;

    typedef enum logic [1:0] {
        KSEL_MIX_A,
        KSEL_MIX_B,
        KSEL_OUT
    } ksel_t;

    typedef enum logic [2:0] {
        C_NONE,
        C_ALWAYS,
        C_SKIP,        // ignored kind or empty fill
        C_SEEDED,      // draw/fill with the block already seeded
        C_KIND_SEED,
        C_NEXT_WORD    // byte index crossed a word boundary
    } cond_t;

    typedef struct packed {
        op_t              op;
        ksel_t            ksel;
        cond_t            cond;
        logic [PC_W-1:0]  target;
    } ctl_t;

    localparam logic [PC_W-1:0] ADDR_START = 5'd0;
    localparam logic [PC_W-1:0] ADDR_DRAW  = 5'd13;
    localparam logic [PC_W-1:0] ADDR_EMIT  = 5'd17;
    localparam logic [PC_W-1:0] ADDR_END   = 5'd18;

    function automatic logic [WORD_W-1:0] mul_const(input ksel_t ksel);
        logic [WORD_W-1:0] k;
        unique case (ksel)
            KSEL_MIX_A: k = MIX_MUL_A;
            KSEL_MIX_B: k = MIX_MUL_B;
            KSEL_OUT:   k = OUT_MUL;
            default:    k = OUT_MUL;
        endcase
        return k;
    endfunction

    function automatic ctl_t ucode_rom(input logic [PC_W-1:0] pc);
        ctl_t c;
        unique case (pc)
            5'd0:  c = '{OP_NOP,    KSEL_MIX_A, C_SKIP,      ADDR_END};
            5'd1:  c = '{OP_NOP,    KSEL_MIX_A, C_SEEDED,    ADDR_DRAW};
            5'd2:  c = '{OP_LOAD,   KSEL_MIX_A, C_NONE,      ADDR_START};
            5'd3:  c = '{OP_MIX,    KSEL_MIX_A, C_NONE,      ADDR_START};
            5'd4:  c = '{OP_MUL0,   KSEL_MIX_A, C_NONE,      ADDR_START};
            5'd5:  c = '{OP_MUL1,   KSEL_MIX_A, C_NONE,      ADDR_START};
            5'd6:  c = '{OP_MUL2,   KSEL_MIX_A, C_NONE,      ADDR_START};
            5'd7:  c = '{OP_MIX,    KSEL_MIX_B, C_NONE,      ADDR_START};
            5'd8:  c = '{OP_MUL0,   KSEL_MIX_B, C_NONE,      ADDR_START};
            5'd9:  c = '{OP_MUL1,   KSEL_MIX_B, C_NONE,      ADDR_START};
            5'd10: c = '{OP_MUL2,   KSEL_MIX_B, C_NONE,      ADDR_START};
            5'd11: c = '{OP_MIX,    KSEL_MIX_B, C_NONE,      ADDR_START};
            5'd12: c = '{OP_ABSORB, KSEL_MIX_B, C_KIND_SEED, ADDR_END};
            5'd13: c = '{OP_STEP,   KSEL_OUT,   C_NONE,      ADDR_START};
            5'd14: c = '{OP_MUL0,   KSEL_OUT,   C_NONE,      ADDR_START};
            5'd15: c = '{OP_MUL1,   KSEL_OUT,   C_NONE,      ADDR_START};
            5'd16: c = '{OP_MUL2,   KSEL_OUT,   C_NONE,      ADDR_START};
            5'd17: c = '{OP_EMIT,   KSEL_OUT,   C_NEXT_WORD, ADDR_DRAW};
            5'd18: c = '{OP_FINISH, KSEL_OUT,   C_NONE,      ADDR_START};
            default: c = '{OP_FINISH, KSEL_OUT, C_NONE,      ADDR_START};
        endcase
        return c;
    endfunction

endpackage

// File: src/xsr_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsr_req_if
// Request channel: kind, value and byte count with valid/ready.
// ----------------------------------------------------------------------------
interface xsr_req_if;
    import xsr_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [WORD_W-1:0]   value;
    logic [COUNT_W-1:0]  byte_count;

    modport source (output valid, output kind, output value, output byte_count,
                    input ready);
    modport sink   (input valid, input kind, input value, input byte_count,
                    output ready);
endinterface

// File: src/xsr_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsr_rsp_if
// Result channel: random word or byte and a last marker with valid/ready.
// ----------------------------------------------------------------------------
interface xsr_rsp_if;
    import xsr_pkg::*;

    logic                valid;
    logic                ready;
    logic [WORD_W-1:0]   word;
    logic                last;

    modport source (output valid, output word, output last, input ready);
    modport sink   (input valid, input word, input last, output ready);
endinterface

// File: src/xorshift64_star_rng_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xorshift64_star_rng_core
// xorshift64* generator with splitmix-style seed mixing, run by a microcoded
// sequencer over one 32x32 multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request: kind 0 seeds, kind 1 draws a 64-bit word,
//   kind 2 fills byte_count bytes (clamped to 64), kind 3 is ignored.
//   rsp returns results; last marks the final result of a request.
//   One request is worked on at a time; req.ready is low while busy.
//   Each 64-bit product takes three passes of the shared 32x32 multiplier;
//   an unseeded draw or fill seeds itself inline from its value first.
//   A result is registered and shows on rsp in the cycle after its emit step.
//   Results sit in an output register; while it is full and rsp.ready is low
//   the emit step waits and the sequencer holds.
//   Reset loads the state with the golden constant and clears seeded.
// ----------------------------------------------------------------------------
module xorshift64_star_rng_core (
    input  logic clk,
    input  logic rst_n,
    xsr_req_if.sink   req,
    xsr_rsp_if.source rsp
);
    import xsr_pkg::*;

    logic                busy_reg,    busy_next;
    logic [PC_W-1:0]     pc_reg,      pc_next;
    logic [KIND_W-1:0]   kind_reg,    kind_next;
    logic [WORD_W-1:0]   value_reg,   value_next;
    logic [COUNT_W-1:0]  count_reg,   count_next;
    logic [COUNT_W-1:0]  idx_reg,     idx_next;
    logic [WORD_W-1:0]   st_reg,      st_next;
    logic                seeded_reg,  seeded_next;
    logic [WORD_W-1:0]   acc_reg,     acc_next;
    logic [WORD_W-1:0]   prod_reg,    prod_next;
    logic                ovalid_reg,  ovalid_next;
    logic [WORD_W-1:0]   oword_reg,   oword_next;
    logic                olast_reg,   olast_next;

    ctl_t                ctl;
    logic [WORD_W-1:0]   kmul;
    logic [HALF_W-1:0]   mul_a;
    logic [HALF_W-1:0]   mul_b;
    logic [WORD_W-1:0]   mul_p;
    logic [WORD_W-1:0]   x1, x2, x3;
    logic [WORD_W-1:0]   absorb_v;
    logic [COUNT_W-1:0]  idx_plus;
    logic                req_fire;
    logic                emit_fire;
    logic                is_last;
    logic                cond_hit;

    assign ctl      = ucode_rom(pc_reg);
    assign kmul     = mul_const(ctl.ksel);
    assign req_fire = req.valid && req.ready;

    // shared 32x32 multiplier, three passes give the low 64 bits
    assign mul_a = (ctl.op == OP_MUL1) ? acc_reg[WORD_W-1:HALF_W] : acc_reg[HALF_W-1:0];
    assign mul_b = (ctl.op == OP_MUL2) ? kmul[WORD_W-1:HALF_W] : kmul[HALF_W-1:0];
    assign mul_p = WORD_W'(mul_a) * WORD_W'(mul_b);

    assign x1       = st_reg ^ (st_reg >> 12);
    assign x2       = x1 ^ (x1 << 25);
    assign x3       = x2 ^ (x2 >> 27);
    assign absorb_v = st_reg ^ acc_reg;

    assign idx_plus  = idx_reg + COUNT_W'(1);
    assign is_last   = (kind_reg == KIND_DRAW) || (idx_plus == count_reg);
    assign emit_fire = busy_reg && (ctl.op == OP_EMIT) && (!ovalid_reg || rsp.ready);

    always_comb
    begin
        case (ctl.cond)
            C_ALWAYS:    cond_hit = 1'b1;
            C_SKIP:      cond_hit = !((kind_reg == KIND_SEED) || (kind_reg == KIND_DRAW)
                                      || (kind_reg == KIND_FILL))
                                    || ((kind_reg == KIND_FILL) && (count_reg == '0));
            C_SEEDED:    cond_hit = (kind_reg != KIND_SEED) && seeded_reg;
            C_KIND_SEED: cond_hit = (kind_reg == KIND_SEED);
            C_NEXT_WORD: cond_hit = (idx_plus[2:0] == 3'd0);
            default:     cond_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        busy_next   = busy_reg;
        pc_next     = pc_reg;
        kind_next   = kind_reg;
        value_next  = value_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        st_next     = st_reg;
        seeded_next = seeded_reg;
        acc_next    = acc_reg;
        prod_next   = prod_reg;
        oword_next  = oword_reg;
        olast_next  = olast_reg;
        ovalid_next = (ovalid_reg && !rsp.ready) || emit_fire;

        if (req_fire)
        begin
            busy_next  = 1'b1;
            pc_next    = ADDR_START;
            kind_next  = req.kind;
            value_next = req.value;
            count_next = (req.byte_count > MAX_FILL_BYTES) ? MAX_FILL_BYTES : req.byte_count;
            idx_next   = '0;
        end
        else if (busy_reg)
        begin
            pc_next = cond_hit ? ctl.target : pc_reg + PC_W'(1);
            unique case (ctl.op)
                OP_NOP: ;
                OP_LOAD:  acc_next = value_reg + GOLDEN;
                OP_MIX:   acc_next = acc_reg ^ (acc_reg >> 33);
                OP_MUL0:  prod_next = mul_p;
                OP_MUL1:  prod_next = prod_reg + {mul_p[HALF_W-1:0], {HALF_W{1'b0}}};
                OP_MUL2:  acc_next = prod_reg + {mul_p[HALF_W-1:0], {HALF_W{1'b0}}};
                OP_ABSORB:
                begin
                    st_next     = (absorb_v == '0) ? ZERO_SUBST : absorb_v;
                    seeded_next = 1'b1;
                end
                OP_STEP:
                begin
                    st_next  = x3;
                    acc_next = x3;
                end
                OP_EMIT:
                begin
                    pc_next = pc_reg;
                    if (emit_fire)
                    begin
                        if (kind_reg == KIND_DRAW)
                            oword_next = acc_reg;
                        else
                            oword_next = {{(WORD_W-8){1'b0}}, acc_reg[7:0]};
                        olast_next = is_last;
                        acc_next   = acc_reg >> 8;
                        idx_next   = idx_plus;
                        if (is_last)
                            busy_next = 1'b0;
                        else if (cond_hit)
                            pc_next = ctl.target;
                    end
                end
                OP_FINISH: busy_next = 1'b0;
                default:   busy_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            pc_reg     <= ADDR_START;
            st_reg     <= GOLDEN;
            seeded_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            busy_reg   <= busy_next;
            pc_reg     <= pc_next;
            st_reg     <= st_next;
            seeded_reg <= seeded_next;
            ovalid_reg <= ovalid_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        value_reg <= value_next;
        count_reg <= count_next;
        acc_reg   <= acc_next;
        prod_reg  <= prod_next;
        oword_reg <= oword_next;
        olast_reg <= olast_next;
    end

    assign req.ready = !busy_reg;
    assign rsp.valid = ovalid_reg;
    assign rsp.word  = oword_reg;
    assign rsp.last  = olast_reg;

    // xorshift is invertible and absorb substitutes zero, so state never hits 0
    a_state_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg != '0)
        else $error("generator state became zero");

    a_seeded_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        seeded_reg |=> seeded_reg)
        else $error("seeded flag dropped");

    a_last_ends_request: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && is_last) |=> !busy_reg)
        else $error("request still busy after last result");

    a_seed_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |-> (kind_reg != KIND_SEED) && seeded_reg)
        else $error("result emitted for a seed request or while unseeded");

    a_fill_byte_only: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && (kind_reg == KIND_FILL)) |=> (rsp.word[WORD_W-1:8] == '0))
        else $error("fill result carries bits above the byte");

endmodule

// File: tb/tb_xorshift64_star_rng_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_xorshift64_star_rng_core
// Self-checking bench for the xorshift64* generator. A driver plays requests
// (seed, draw, fill, ignored kind) from a queue and mirrors the generator
// state at each accepted request to build the expected words and bytes. A
// monitor compares every result with the oldest expectation. Both sides stall
// in random bursts, except near the end of the run.
// ----------------------------------------------------------------------------
module tb_xorshift64_star_rng_core;
    import xsr_pkg::*;

    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;   // decoded as nothing
    localparam int                WATCHDOG_LIMIT = 4000;
    localparam int                RANDOM_REQS = 75;
    localparam int                QUIET_TAIL = 20;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [WORD_W-1:0]  value;
        logic [COUNT_W-1:0] byte_count;
        bit                 hold;      // wait for all results before sending
        bit                 cancel;    // seed chosen to zero the state
    } rng_req_t;

    typedef struct {
        logic [WORD_W-1:0] word;
        logic              last;
    } rng_out_t;

    logic clk = 1'b0;
    logic rst_n;

    xsr_req_if req_ch ();
    xsr_rsp_if rsp_ch ();

    xorshift64_star_rng_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    always #5 clk = ~clk;

    rng_req_t    req_q[$];
    rng_out_t    rng_out_q[$];
    rng_req_t    cur_req;
    logic        req_fire;
    logic        quiet_phase;
    int unsigned gap_left;
    int unsigned stall_left;
    int unsigned idle_cycles = 0;
    int unsigned err_count = 0;

    // mirror of the generator
    logic [WORD_W-1:0] gen_state = GOLDEN;
    bit                gen_seeded = 1'b0;

    int unsigned n_seed, n_draw, n_fill, n_fill_bytes, n_ignored;
    int unsigned n_zero_subst, n_results;

    function automatic logic [WORD_W-1:0] splitmix_finish(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] x;
        x = v;
        x = x ^ (x >> 33);
        x = x * MIX_MUL_A;
        x = x ^ (x >> 33);
        x = x * MIX_MUL_B;
        x = x ^ (x >> 33);
        return x;
    endfunction

    // inverse of an odd constant mod 2^64 by Newton iteration
    function automatic logic [WORD_W-1:0] odd_inverse(input logic [WORD_W-1:0] k);
        logic [WORD_W-1:0] inv;
        inv = k;
        for (int i = 0; i < 6; i++)
            inv = inv * (64'd2 - k * inv);
        return inv;
    endfunction

    // x ^= x >> 33 is its own inverse
    function automatic logic [WORD_W-1:0] splitmix_undo(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] x;
        x = v;
        x = x ^ (x >> 33);
        x = x * odd_inverse(MIX_MUL_B);
        x = x ^ (x >> 33);
        x = x * odd_inverse(MIX_MUL_A);
        x = x ^ (x >> 33);
        return x;
    endfunction

    task automatic absorb_seed(input logic [WORD_W-1:0] s);
        gen_state = gen_state ^ splitmix_finish(s + GOLDEN);
        if (gen_state == '0)
        begin
            gen_state = ZERO_SUBST;
            n_zero_subst++;
        end
        gen_seeded = 1'b1;
    endtask

    task automatic next_word(input logic [WORD_W-1:0] entropy,
                             output logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] s;
        if (!gen_seeded)
            absorb_seed(entropy);
        s = gen_state;
        s = s ^ (s >> 12);
        s = s ^ (s << 25);
        s = s ^ (s >> 27);
        gen_state = s;
        w = s * OUT_MUL;
    endtask

    task automatic advance_rng(input rng_req_t r);
        logic [WORD_W-1:0] w;
        rng_out_t          o;
        int unsigned       n;
        w = '0;
        case (r.kind)
            KIND_SEED:
            begin
                absorb_seed(r.value);
                n_seed++;
            end
            KIND_DRAW:
            begin
                next_word(r.value, w);
                o.word = w;
                o.last = 1'b1;
                rng_out_q.push_back(o);
                n_draw++;
            end
            KIND_FILL:
            begin
                n = (r.byte_count > MAX_FILL_BYTES) ? int'(MAX_FILL_BYTES)
                                                    : int'(r.byte_count);
                for (int k = 0; k < n; k++)
                begin
                    if (k % 8 == 0)
                        next_word(r.value, w);
                    o.word = {56'd0, w[7:0]};
                    o.last = (k + 1 == n);
                    rng_out_q.push_back(o);
                    w = w >> 8;
                end
                n_fill++;
                n_fill_bytes += n;
            end
            default:
                n_ignored++;
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        err_count++;
    endtask

    task automatic check_result(input logic [WORD_W-1:0] word, input logic last);
        rng_out_t e;
        if (rng_out_q.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result word=%h last=%b", word, last));
        end
        else
        begin
            e = rng_out_q.pop_front();
            n_results++;
            if (word !== e.word)
                report_mismatch($sformatf("word %h, expected %h", word, e.word));
            if (last !== e.last)
                report_mismatch($sformatf("last %b, expected %b (word %h)",
                                          last, e.last, e.word));
        end
    endtask

    task automatic add_req(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] value,
                           input logic [COUNT_W-1:0] byte_count,
                           input bit hold, input bit cancel);
        rng_req_t r;
        r.kind = kind;
        r.value = value;
        r.byte_count = byte_count;
        r.hold = hold;
        r.cancel = cancel;
        req_q.push_back(r);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid      <= 1'b0;
            req_ch.kind       <= KIND_SEED;
            req_ch.value      <= '0;
            req_ch.byte_count <= '0;
            gap_left          <= 0;
            quiet_phase       <= 1'b0;
        end
        else
        begin
            req_fire = req_ch.valid && req_ch.ready;
            if (req_fire)
                advance_rng(cur_req);
            quiet_phase <= (req_q.size() <= QUIET_TAIL);
            if (!req_ch.valid || req_fire)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    req_ch.valid <= 1'b0;
                end
                else if (req_q.size() == 0 || (req_q[0].hold && rng_out_q.size() != 0))
                begin
                    req_ch.valid <= 1'b0;
                end
                else if (!quiet_phase && $urandom_range(0, 7) == 0)
                begin
                    gap_left <= $urandom_range(0, 14);
                    req_ch.valid <= 1'b0;
                end
                else
                begin
                    cur_req = req_q.pop_front();
                    // pick the seed that cancels the current state exactly
                    if (cur_req.cancel)
                        cur_req.value = splitmix_undo(gen_state) - GOLDEN;
                    req_ch.valid      <= 1'b1;
                    req_ch.kind       <= cur_req.kind;
                    req_ch.value      <= cur_req.value;
                    req_ch.byte_count <= cur_req.byte_count;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                check_result(rsp_ch.word, rsp_ch.last);
            if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                rsp_ch.ready <= 1'b0;
            end
            else if (!quiet_phase && $urandom_range(0, 9) == 0)
            begin
                stall_left <= $urandom_range(0, 14);
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t ns: watchdog expired, %0d results outstanding",
                         $time, rng_out_q.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned counted;
        int unsigned pick;
        logic [COUNT_W-1:0] cnt;
        rst_n = 1'b0;
        counted = 0;

        // directed: empty fill and ignored kind before seeding leave state alone
        add_req(KIND_FILL, {$urandom, $urandom}, 7'd0, 1'b0, 1'b0);
        add_req(KIND_NONE, {64{1'b1}}, 7'd127, 1'b0, 1'b0);
        // unseeded fill seeds from its value first
        add_req(KIND_FILL, 64'd0, 7'd13, 1'b0, 1'b0);
        add_req(KIND_DRAW, {64{1'b1}}, 7'd127, 1'b0, 1'b0);
        add_req(KIND_SEED, 64'd0, 7'd0, 1'b1, 1'b0);
        add_req(KIND_DRAW, 64'd0, 7'd0, 1'b0, 1'b0);
        add_req(KIND_SEED, {64{1'b1}}, 7'd0, 1'b0, 1'b0);
        add_req(KIND_SEED, 64'd0, 7'd0, 1'b0, 1'b1);       // seed would zero the state
        add_req(KIND_DRAW, {32{2'b10}}, 7'd0, 1'b0, 1'b0);
        add_req(KIND_FILL, {32{2'b01}}, 7'd1, 1'b0, 1'b0);
        add_req(KIND_FILL, 64'd0, 7'd7, 1'b0, 1'b0);
        add_req(KIND_FILL, 64'd0, 7'd8, 1'b0, 1'b0);
        add_req(KIND_FILL, 64'd0, 7'd9, 1'b0, 1'b0);
        add_req(KIND_FILL, 64'd0, 7'd16, 1'b0, 1'b0);
        add_req(KIND_FILL, 64'd0, MAX_FILL_BYTES, 1'b0, 1'b0);
        add_req(KIND_FILL, {64{1'b1}}, 7'd65, 1'b0, 1'b0);  // clamped
        add_req(KIND_FILL, 64'd0, 7'd127, 1'b1, 1'b0);      // clamped
        add_req(KIND_FILL, {64{1'b1}}, 7'd0, 1'b0, 1'b0);
        add_req(KIND_NONE, 64'd0, 7'd0, 1'b0, 1'b0);
        add_req(KIND_SEED, {32{2'b10}}, 7'd0, 1'b0, 1'b0);
        add_req(KIND_SEED, {32{2'b01}}, 7'd0, 1'b0, 1'b0);
        add_req(KIND_DRAW, {$urandom, $urandom}, 7'd0, 1'b0, 1'b0);

        // random part, mostly draws and short fills
        while (counted < RANDOM_REQS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
            begin
                add_req(KIND_SEED, {$urandom, $urandom}, COUNT_W'($urandom), 1'b0,
                        pick < 2);
                counted++;
            end
            else if (pick < 45)
            begin
                add_req(KIND_DRAW, {$urandom, $urandom}, COUNT_W'($urandom),
                        $urandom_range(0, 14) == 0, 1'b0);
                counted++;
            end
            else if (pick < 93)
            begin
                if ($urandom_range(0, 19) == 0)
                    cnt = 7'd0;
                else if ($urandom_range(0, 7) == 0)
                    cnt = COUNT_W'($urandom_range(25, 127));
                else
                    cnt = COUNT_W'($urandom_range(1, 24));
                add_req(KIND_FILL, {$urandom, $urandom}, cnt, $urandom_range(0, 14) == 0,
                        1'b0);
                counted++;
            end
            else
            begin
                add_req(KIND_NONE, {$urandom, $urandom}, COUNT_W'($urandom), 1'b0, 1'b0);
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (req_q.size() != 0 || req_ch.valid)
            @(posedge clk);
        while (rng_out_q.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);

        $display("Covered %0d seeds (%0d zeroed states), %0d draws,", n_seed, n_zero_subst,
                 n_draw);
        $display("%0d fills (%0d bytes), %0d ignored; checked %0d results, %0d mismatches.",
                 n_fill, n_fill_bytes, n_ignored, n_results, err_count);
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: xorshift64_star_rng_core.f
src/xsr_pkg.sv
src/xsr_req_if.sv
src/xsr_rsp_if.sv
src/xorshift64_star_rng_core.sv
tb/tb_xorshift64_star_rng_core.sv
